// ===== hdl/http_chunked_body_deframer_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef HTTP_CHUNKED_BODY_DEFRAMER_UNIT_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DEFRAMER_UNIT_ASSERT_SVH

// clocked check, quiet while reset is applied
`define HCBD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hcbd check failed");

// clocked check that also runs through reset
`define HCBD_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hcbd reset check failed");

`endif

// ===== hdl/hcbd_pkg.sv =====
package hcbd_pkg;

  localparam int SIZE_DIGITS  = 8;
  localparam int SIZE_BITS    = 4 * SIZE_DIGITS;
  localparam int DCNT_W       = $clog2(SIZE_DIGITS + 1);
  localparam int LENGTH_WIDTH = 40;

  // queue depth between stages
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [1:0] CFG_IDX_CHUNKED  = 2'd0;
  localparam logic [1:0] CFG_IDX_LENGTH   = 2'd1;
  localparam logic [1:0] CFG_IDX_UNTIL_CL = 2'd2;

  // trailer line content tracking
  localparam logic [1:0] TL_EMPTY = 2'd0;
  localparam logic [1:0] TL_CR    = 2'd1;
  localparam logic [1:0] TL_TEXT  = 2'd2;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_SEP     = 3'd2,
    PH_TRAILER = 3'd3,
    PH_DONE    = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  typedef struct packed {
    logic                    chunked_mode;
    logic [LENGTH_WIDTH-1:0] body_length;
    logic                    until_close;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_lf;
    logic       is_cr;
    logic       is_blank;
    logic       is_hex;
    logic [3:0] hex_val;
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    logic       payload_valid;
    logic       chunk_end;
    logic [1:0] status;
  } res_t;

  function automatic cls_t classify(logic [7:0] b, logic start);
    cls_t c;
    c.data     = b;
    c.start    = start;
    c.is_lf    = (b == CH_LF);
    c.is_cr    = (b == CH_CR);
    c.is_blank = (b inside {CH_SP, CH_TAB});
    c.is_hex   = 1'b0;
    c.hex_val  = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      c.is_hex  = 1'b1;
      c.hex_val = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      c.is_hex  = 1'b1;
      c.hex_val = 4'(b[3:0] + 4'd9);
    end
    return c;
  endfunction

endpackage

// ===== hdl/hcbd_front.sv =====
module hcbd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    data_byte,
  input  logic          start_message,
  output logic          deq_valid,
  input  logic          deq_pop,
  output hcbd_pkg::cls_t deq_data
);
  import hcbd_pkg::*;

  cls_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push_ok;
  logic              pop_ok;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign deq_valid = (count_r != '0);
  assign deq_data  = q_r[rd_ptr_r];
  assign push_ok   = push && !full;
  assign pop_ok    = deq_pop && deq_valid;

  always_comb begin
    wr_ptr_nxt = push_ok ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // byte is classified on the way in
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= classify(data_byte, start_message);
    end
  end

endmodule

// ===== hdl/hcbd_back.sv =====
module hcbd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hcbd_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_pop,
  input  hcbd_pkg::cls_t in_data,
  output logic           empty,
  input  logic           pop,
  output hcbd_pkg::res_t res
);
  import hcbd_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]    remain_r, remain_nxt;
  logic [SIZE_BITS-1:0]    acc_r, acc_nxt;
  logic [DCNT_W-1:0]       dcnt_r, dcnt_nxt;
  logic                    ended_r, ended_nxt;
  logic [1:0]              tline_r, tline_nxt;
  logic [LENGTH_WIDTH-1:0] lrecv_r, lrecv_nxt;

  phase_t                  ph_cur;
  logic [SIZE_BITS-1:0]    remain_cur, acc_cur, remain_dec;
  logic [DCNT_W-1:0]       dcnt_cur;
  logic                    ended_cur;
  logic [1:0]              tline_cur;
  logic [LENGTH_WIDTH-1:0] lrecv_cur, lrecv_inc;
  logic                    lrecv_lt, remain_last, dcnt_full;

  logic                    pv, ce;
  logic [1:0]              st;

  res_t              oq_r [QDEPTH];
  logic [QPTR_W-1:0] owr_r, ord_r;
  logic [QCNT_W-1:0] ocnt_r, ocnt_nxt;
  logic              take, pop_ok;

  assign take   = in_valid && (ocnt_r != QCNT_W'(QDEPTH));
  assign in_pop = take;
  assign empty  = (ocnt_r == '0);
  assign pop_ok = pop && !empty;
  assign res    = oq_r[ord_r];

  // start of message clears the state before the byte is handled
  assign ph_cur     = in_data.start ? PH_SIZE : phase_r;
  assign remain_cur = in_data.start ? '0 : remain_r;
  assign acc_cur    = in_data.start ? '0 : acc_r;
  assign dcnt_cur   = in_data.start ? '0 : dcnt_r;
  assign ended_cur  = in_data.start ? 1'b0 : ended_r;
  assign tline_cur  = in_data.start ? TL_EMPTY : tline_r;
  assign lrecv_cur  = in_data.start ? '0 : lrecv_r;

  assign lrecv_inc   = LENGTH_WIDTH'(lrecv_cur + 1'b1);
  assign lrecv_lt    = (lrecv_cur < cfg.body_length);
  assign remain_dec  = (remain_cur != '0) ? SIZE_BITS'(remain_cur - 1'b1) : remain_cur;
  assign remain_last = (remain_dec == '0);
  assign dcnt_full   = (dcnt_cur >= DCNT_W'(SIZE_DIGITS));

  // next state
  always_comb begin
    phase_nxt  = ph_cur;
    remain_nxt = remain_cur;
    acc_nxt    = acc_cur;
    dcnt_nxt   = dcnt_cur;
    ended_nxt  = ended_cur;
    tline_nxt  = tline_cur;
    lrecv_nxt  = lrecv_cur;
    if (!cfg.chunked_mode) begin
      if (!cfg.until_close && lrecv_lt) begin
        lrecv_nxt = lrecv_inc;
      end
    end else begin
      case (ph_cur)
        PH_SIZE: begin
          if (in_data.is_lf) begin
            if (dcnt_cur == '0) begin
              phase_nxt = PH_ERROR;
            end else if (acc_cur == '0) begin
              phase_nxt = PH_TRAILER;
              tline_nxt = TL_EMPTY;
            end else begin
              remain_nxt = acc_cur;
              phase_nxt  = PH_DATA;
            end
          end else if (!ended_cur) begin
            if (in_data.is_hex) begin
              if (dcnt_full) begin
                phase_nxt = PH_ERROR;
              end else begin
                acc_nxt  = {acc_cur[SIZE_BITS-5:0], in_data.hex_val};
                dcnt_nxt = DCNT_W'(dcnt_cur + 1'b1);
              end
            end else if (!(in_data.is_blank && dcnt_cur == '0)) begin
              ended_nxt = 1'b1;
            end
          end
        end
        PH_DATA: begin
          remain_nxt = remain_dec;
          if (remain_last) begin
            phase_nxt = PH_SEP;
          end
        end
        PH_SEP: begin
          if (in_data.is_lf) begin
            phase_nxt = PH_SIZE;
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            ended_nxt = 1'b0;
          end
        end
        PH_TRAILER: begin
          if (in_data.is_lf) begin
            if (tline_cur != TL_TEXT) begin
              phase_nxt = PH_DONE;
            end
            tline_nxt = TL_EMPTY;
          end else if (in_data.is_cr && tline_cur == TL_EMPTY) begin
            tline_nxt = TL_CR;
          end else begin
            tline_nxt = TL_TEXT;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase
    end
  end

  // result flags
  always_comb begin
    pv = 1'b0;
    ce = 1'b0;
    st = ST_BUSY;
    if (!cfg.chunked_mode) begin
      if (cfg.until_close) begin
        pv = 1'b1;
      end else if (lrecv_lt) begin
        pv = 1'b1;
        if (lrecv_inc == cfg.body_length) begin
          ce = 1'b1;
          st = ST_DONE;
        end
      end else begin
        st = ST_DONE;
      end
    end else begin
      case (ph_cur)
        PH_SIZE: begin
          if (in_data.is_lf) begin
            if (dcnt_cur == '0) begin
              st = ST_ERROR;
            end
          end else if (!ended_cur && in_data.is_hex && dcnt_full) begin
            st = ST_ERROR;
          end
        end
        PH_DATA: begin
          pv = 1'b1;
          ce = remain_last;
        end
        PH_SEP: begin
          st = ST_BUSY;
        end
        PH_TRAILER: begin
          if (in_data.is_lf && tline_cur != TL_TEXT) begin
            st = ST_DONE;
          end
        end
        PH_DONE: begin
          st = ST_DONE;
        end
        default: begin
          st = ST_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (take && !pop_ok) begin
      ocnt_nxt = QCNT_W'(ocnt_r + 1'b1);
    end else if (pop_ok && !take) begin
      ocnt_nxt = QCNT_W'(ocnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIZE;
      remain_r <= '0;
      acc_r    <= '0;
      dcnt_r   <= '0;
      ended_r  <= 1'b0;
      tline_r  <= TL_EMPTY;
      lrecv_r  <= '0;
      owr_r    <= '0;
      ord_r    <= '0;
      ocnt_r   <= '0;
    end else begin
      if (take) begin
        phase_r  <= phase_nxt;
        remain_r <= remain_nxt;
        acc_r    <= acc_nxt;
        dcnt_r   <= dcnt_nxt;
        ended_r  <= ended_nxt;
        tline_r  <= tline_nxt;
        lrecv_r  <= lrecv_nxt;
        owr_r    <= QPTR_W'(owr_r + 1'b1);
      end
      if (pop_ok) begin
        ord_r <= QPTR_W'(ord_r + 1'b1);
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      oq_r[owr_r] <= '{data: in_data.data, payload_valid: pv, chunk_end: ce, status: st};
    end
  end

endmodule

// ===== hdl/http_chunked_body_deframer_unit.sv =====
// path: a byte accepted is stored in the front queue, parsed into the back queue, then shows on the result ports
// throughput: one beat per clock while neither queue is full; the parse stage updates its state once per beat
// both sides stall independently through two-entry queues around the parse stage
// reset (rst_n low at a clock edge) empties both queues, clears the parse state
// and sets chunked_mode, body_length and until_close to zero; no clearing pass
module http_chunked_body_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_message,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_payload_valid,
  output logic        out_chunk_end,
  output logic [1:0]  out_status,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [hcbd_pkg::LENGTH_WIDTH-1:0] cfg_data
);
  import hcbd_pkg::*;

  // configuration registers, to be written by the user only while the block is idle; nothing in the block enforces this
  logic                    chunked_mode_r;
  logic [LENGTH_WIDTH-1:0] body_length_r;
  logic                    until_close_r;
  cfg_t                    cfg;

  // link between front (classify) and back (parse) stages
  logic deq_valid;
  logic deq_pop;
  cls_t deq_data;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunked_mode_r <= 1'b0;
      body_length_r  <= '0;
      until_close_r  <= 1'b0;
    end else if (cfg_we) begin
      // an index past the register list is dropped
      case (cfg_index)
        CFG_IDX_CHUNKED:  chunked_mode_r <= cfg_data[0];
        CFG_IDX_LENGTH:   body_length_r  <= cfg_data;
        CFG_IDX_UNTIL_CL: until_close_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{chunked_mode: chunked_mode_r, body_length: body_length_r,
                 until_close: until_close_r};

  // front: takes beats, tags line feed, carriage return, blanks and hex digits
  hcbd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .data_byte     (in_data_byte),
    .start_message (in_start_message),
    .deq_valid     (deq_valid),
    .deq_pop       (deq_pop),
    .deq_data      (deq_data)
  );

  // back: runs the length counter, the until-close pass-through or the chunk parser, queues results
  hcbd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (deq_valid),
    .in_pop   (deq_pop),
    .in_data  (deq_data),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

  assign out_byte          = res.data;
  assign out_payload_valid = res.payload_valid;
  assign out_chunk_end     = res.chunk_end;
  assign out_status        = res.status;

endmodule

// ===== hdl/hcbd_checker.sv =====
`include "http_chunked_body_deframer_unit_assert.svh"

module hcbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       out_payload_valid,
  input logic       out_chunk_end,
  input logic [1:0] out_status
);
  import hcbd_pkg::*;

  logic status_known;

  assign status_known = (out_status == ST_BUSY) || (out_status == ST_DONE) ||
                        (out_status == ST_ERROR);

  `HCBD_ASSERT_RST(a_rst_empty, clk, !rst_n |=> empty)
  `HCBD_ASSERT_RST(a_rst_not_full, clk, !rst_n |=> !full)
  `HCBD_ASSERT(a_status_code, clk, rst_n, !empty |-> status_known)
  `HCBD_ASSERT(a_end_is_payload, clk, rst_n, (!empty && out_chunk_end) |-> out_payload_valid)
  `HCBD_ASSERT(a_stall_holds, clk, rst_n, (!empty && !pop) |=> !empty)

endmodule

bind http_chunked_body_deframer_unit hcbd_checker u_hcbd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_payload_valid (out_payload_valid),
  .out_chunk_end     (out_chunk_end),
  .out_status        (out_status)
);
